// ===== hdl/ftl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftl_pkg: shared types and constants for the token lexer
// Character classes, the front-to-back queue entry and token kind codes.
// ----------------------------------------------------------------------------
package ftl_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] class_t;
  typedef logic [1:0] done_t;

  // character classes, most specific first
  localparam class_t CL_NONPRINT = 4'd0;
  localparam class_t CL_SPACE    = 4'd1;
  localparam class_t CL_DIGIT    = 4'd2;
  localparam class_t CL_SIGN     = 4'd3;
  localparam class_t CL_EXP      = 4'd4;
  localparam class_t CL_DOT      = 4'd5;
  localparam class_t CL_QUOTE    = 4'd6;
  localparam class_t CL_BSLASH   = 4'd7;
  localparam class_t CL_PRINT    = 4'd8;

  // kind of token a character completes
  localparam done_t DONE_NONE   = 2'd0;
  localparam done_t DONE_NUMBER = 2'd1;
  localparam done_t DONE_STRING = 2'd2;
  localparam done_t DONE_SYMBOL = 2'd3;

  // one classified character on its way to the automaton
  typedef struct packed {
    char_t  ch;
    class_t cls;
  } lex_item_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== hdl/ftl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftl_front: input stage
// Takes one character per transfer, classifies it and registers the result.
// ----------------------------------------------------------------------------
module ftl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ftl_pkg::char_t    in_char,
  output logic              item_valid,
  input  logic              item_ready,
  output ftl_pkg::lex_item_t item
);
  import ftl_pkg::*;

  class_t    cls;
  logic      vld_r;
  logic      vld_nxt;
  lex_item_t item_r;

  always_comb begin
    if (in_char == 8'h20) begin
      cls = CL_SPACE;
    end else if (in_char >= 8'h30 && in_char <= 8'h39) begin
      cls = CL_DIGIT;
    end else if (in_char == 8'h2B || in_char == 8'h2D) begin
      cls = CL_SIGN;
    end else if (in_char == 8'h65 || in_char == 8'h45) begin
      cls = CL_EXP;
    end else if (in_char == 8'h2E) begin
      cls = CL_DOT;
    end else if (in_char == 8'h22) begin
      cls = CL_QUOTE;
    end else if (in_char == 8'h5C) begin
      cls = CL_BSLASH;
    end else if (in_char > 8'h20 && in_char < 8'h7F) begin
      cls = CL_PRINT;
    end else begin
      cls = CL_NONPRINT;
    end
  end

  assign in_ready   = !vld_r || item_ready;
  assign vld_nxt    = in_ready ? in_valid : vld_r;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.ch  <= in_char;
      item_r.cls <= cls;
    end
  end

endmodule

// ===== hdl/ftl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftl_queue: short queue between front and back
// Circular buffer of classified characters; registered entries.
// ----------------------------------------------------------------------------
module ftl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  ftl_pkg::lex_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output ftl_pkg::lex_item_t pop_item
);
  import ftl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  lex_item_t mem [QUEUE_DEPTH];
  ptr_t      wr_ptr_r, wr_ptr_nxt;
  ptr_t      rd_ptr_r, rd_ptr_nxt;
  cnt_t      cnt_r, cnt_nxt;
  logic      push, pop;

  assign push_ready = cnt_r != cnt_t'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + ptr_t'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + ptr_t'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + cnt_t'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // occupancy tracks the pointers
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + cnt_t'(1)))
    else $error("push did not raise count");

endmodule

// ===== hdl/ftl_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftl_engine: lexer automaton and result register
// One state transition per classified character; result held until taken.
// ----------------------------------------------------------------------------
module ftl_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  ftl_pkg::lex_item_t item,
  output logic               out_valid,
  input  logic               out_ready,
  output ftl_pkg::char_t     out_char,
  output logic               out_tok,
  output ftl_pkg::done_t     out_done,
  output logic               out_err
);
  import ftl_pkg::*;

  localparam logic [3:0] ST_NEUTRAL     = 4'd0;
  localparam logic [3:0] ST_SIGN        = 4'd1;
  localparam logic [3:0] ST_DIGITS      = 4'd2;
  localparam logic [3:0] ST_DOT_AFTER   = 4'd3;
  localparam logic [3:0] ST_DOT_BEFORE  = 4'd4;
  localparam logic [3:0] ST_EXP         = 4'd5;
  localparam logic [3:0] ST_FRAC_DIGITS = 4'd6;
  localparam logic [3:0] ST_EXP_SIGN    = 4'd7;
  localparam logic [3:0] ST_EXP_DIGITS  = 4'd8;
  localparam logic [3:0] ST_STR_START   = 4'd9;
  localparam logic [3:0] ST_STR_TEXT    = 4'd10;
  localparam logic [3:0] ST_STR_ESC     = 4'd11;
  localparam logic [3:0] ST_STR_ESCAPED = 4'd12;
  localparam logic [3:0] ST_SYM_CHAR    = 4'd13;

  // targets above the state range end a token or flag an error
  localparam logic [4:0] GO_NUMBER = 5'd16;
  localparam logic [4:0] GO_STRING = 5'd17;
  localparam logic [4:0] GO_SYMBOL = 5'd18;
  localparam logic [4:0] GO_ERROR  = 5'd19;

  logic [3:0] state_r, state_nxt;
  logic [4:0] tgt;
  logic       sp, dg, sg, ex, dt, qt, bs, pr;
  logic       take;
  logic       tok, err;
  done_t      done;

  logic       out_valid_r;
  char_t      out_char_r;
  logic       out_tok_r;
  done_t      out_done_r;
  logic       out_err_r;

  assign sp = item.cls == CL_SPACE;
  assign dg = item.cls == CL_DIGIT;
  assign sg = item.cls == CL_SIGN;
  assign ex = item.cls == CL_EXP;
  assign dt = item.cls == CL_DOT;
  assign qt = item.cls == CL_QUOTE;
  assign bs = item.cls == CL_BSLASH;
  assign pr = item.cls != CL_NONPRINT;

  always_comb begin
    unique case (state_r)
      ST_SIGN: begin
        if (sp)      tgt = GO_SYMBOL;
        else if (dg) tgt = {1'b0, ST_DIGITS};
        else if (dt) tgt = {1'b0, ST_DOT_BEFORE};
        else if (pr) tgt = {1'b0, ST_SYM_CHAR};
        else         tgt = GO_ERROR;
      end
      ST_DIGITS: begin
        if (sp)      tgt = GO_NUMBER;
        else if (dg) tgt = {1'b0, ST_DIGITS};
        else if (ex) tgt = {1'b0, ST_EXP};
        else if (dt) tgt = {1'b0, ST_DOT_AFTER};
        else         tgt = GO_ERROR;
      end
      ST_DOT_AFTER, ST_FRAC_DIGITS: begin
        if (sp)      tgt = GO_NUMBER;
        else if (dg) tgt = {1'b0, ST_FRAC_DIGITS};
        else if (ex) tgt = {1'b0, ST_EXP};
        else         tgt = GO_ERROR;
      end
      ST_DOT_BEFORE: begin
        if (sp)      tgt = GO_SYMBOL;
        else if (dg) tgt = {1'b0, ST_FRAC_DIGITS};
        else if (ex) tgt = {1'b0, ST_EXP};
        else if (pr) tgt = {1'b0, ST_SYM_CHAR};
        else         tgt = GO_ERROR;
      end
      ST_EXP: begin
        if (sg)      tgt = {1'b0, ST_EXP_SIGN};
        else if (dg) tgt = {1'b0, ST_EXP_DIGITS};
        else         tgt = GO_ERROR;
      end
      ST_EXP_SIGN: begin
        if (dg) tgt = {1'b0, ST_EXP_DIGITS};
        else    tgt = GO_ERROR;
      end
      ST_EXP_DIGITS: begin
        if (sp)      tgt = GO_NUMBER;
        else if (dg) tgt = {1'b0, ST_EXP_DIGITS};
        else         tgt = GO_ERROR;
      end
      ST_STR_START: begin
        // no escape right after the opening quote
        if (qt)             tgt = GO_STRING;
        else if (pr && !bs) tgt = {1'b0, ST_STR_TEXT};
        else                tgt = GO_ERROR;
      end
      ST_STR_TEXT, ST_STR_ESCAPED: begin
        if (qt)      tgt = GO_STRING;
        else if (bs) tgt = {1'b0, ST_STR_ESC};
        else if (pr) tgt = {1'b0, ST_STR_TEXT};
        else         tgt = GO_ERROR;
      end
      ST_STR_ESC: begin
        if (pr) tgt = {1'b0, ST_STR_ESCAPED};
        else    tgt = GO_ERROR;
      end
      ST_SYM_CHAR: begin
        if (sp)      tgt = GO_SYMBOL;
        else if (pr) tgt = {1'b0, ST_SYM_CHAR};
        else         tgt = GO_ERROR;
      end
      default: begin
        // neutral, and unused codes behave the same
        if (sp)      tgt = {1'b0, ST_NEUTRAL};
        else if (sg) tgt = {1'b0, ST_SIGN};
        else if (dg) tgt = {1'b0, ST_DIGITS};
        else if (dt) tgt = {1'b0, ST_DOT_BEFORE};
        else if (qt) tgt = {1'b0, ST_STR_START};
        else if (pr) tgt = {1'b0, ST_SYM_CHAR};
        else         tgt = GO_ERROR;
      end
    endcase
  end

  always_comb begin
    done = DONE_NONE;
    err  = 1'b0;
    tok  = 1'b0;
    unique case (tgt)
      GO_NUMBER: done = DONE_NUMBER;
      GO_STRING: done = DONE_STRING;
      GO_SYMBOL: done = DONE_SYMBOL;
      GO_ERROR:  err  = 1'b1;
      default:   tok  = (tgt[3:0] != ST_NEUTRAL) && (tgt[3:0] != ST_STR_START);
    endcase
  end

  assign take       = item_valid && item_ready;
  assign item_ready = !out_valid_r || out_ready;
  assign state_nxt  = !take   ? state_r :
                      tgt[4]  ? ST_NEUTRAL : tgt[3:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_NEUTRAL;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (item_ready) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_char_r <= item.ch;
      out_tok_r  <= tok;
      out_done_r <= done;
      out_err_r  <= err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_tok   = out_tok_r;
  assign out_done  = out_done_r;
  assign out_err   = out_err_r;

  a_end_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (tgt[4] || err)) |=> (state_r == ST_NEUTRAL))
    else $error("automaton not back to neutral after token end or error");
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_done_r == DONE_NONE && !out_tok_r))
    else $error("error result carries token marks");
  a_done_not_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r != DONE_NONE) |-> !out_tok_r)
    else $error("completing character marked as token text");
  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(state_r))
    else $error("state moved without a transfer");

endmodule

// ===== hdl/forth_token_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_token_lexer: character-at-a-time lexer for space-delimited tokens
// Numbers (sign, fraction, exponent), quoted strings with escapes, symbols.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_ready  in_char_in
//   out_      output     out_valid/out_ready  out_char_out, out_in_token,
//                                             out_token_done, out_lex_error
//
// One character per cycle sustained while out_ready holds high; the
// automaton makes one transition per transfer out of a single state
// register. An input transfer reaches out_valid through the classify
// register, the two-entry queue and the result register.
// Synchronous active-low reset puts the automaton in neutral and empties
// every stage. An output stall fills the result register, then the queue,
// then the classify register before in_ready drops.
// ----------------------------------------------------------------------------
module forth_token_lexer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ftl_pkg::char_t in_char_in,
  output logic           out_valid,
  input  logic           out_ready,
  output ftl_pkg::char_t out_char_out,
  output logic           out_in_token,
  output ftl_pkg::done_t out_token_done,
  output logic           out_lex_error
);
  import ftl_pkg::*;

  // front to queue
  logic      f_valid, f_ready;
  lex_item_t f_item;
  // queue to engine
  logic      q_valid, q_ready;
  lex_item_t q_item;

  // classify each character as it arrives
  ftl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char_in),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // decouples the front from stalls at the result side
  ftl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // automaton state and result register
  ftl_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char_out),
    .out_tok    (out_in_token),
    .out_done   (out_token_done),
    .out_err    (out_lex_error)
  );

endmodule

// ===== tb/ftl_token_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftl_token_check: result predictor and comparator for the token lexer
// Tracks the lexer automaton on every input transfer, queues the expected
// result and compares each output transfer with the oldest entry.
// ----------------------------------------------------------------------------
module ftl_token_check (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  ftl_pkg::char_t in_char_in,
  input  logic           out_valid,
  input  logic           out_ready,
  input  ftl_pkg::char_t out_char_out,
  input  logic           out_in_token,
  input  ftl_pkg::done_t out_token_done,
  input  logic           out_lex_error,
  output int             fail_count,
  output int             pending
);
  import ftl_pkg::*;

  localparam int REPORT_MAX = 10;

  // automaton states plus the pseudo-targets of a finished step
  typedef enum logic [4:0] {
    LX_NEUTRAL, LX_SIGN, LX_DIGITS, LX_DOT_AFTER, LX_DOT_BEFORE, LX_EXP,
    LX_FRAC, LX_EXP_SIGN, LX_EXP_DIGITS, LX_STR_START, LX_STR_TEXT,
    LX_STR_ESC, LX_STR_ESCAPED, LX_SYM,
    LX_END_NUMBER, LX_END_STRING, LX_END_SYMBOL, LX_BAD
  } lex_state_e;

  typedef struct packed {
    char_t ch;
    logic  tok;
    done_t done;
    logic  err;
  } lex_result_t;

  lex_state_e  lex_st;
  lex_result_t lex_results_q[$];

  // one transition; space is tested before the general printable class
  function automatic lex_state_e lex_transition(lex_state_e s, char_t c);
    logic sp, dg, sg, ex, dt, qt, bs, pr;
    sp = (c == " ");
    dg = (c >= "0") && (c <= "9");
    sg = (c == "+") || (c == "-");
    ex = (c == "e") || (c == "E");
    dt = (c == ".");
    qt = (c == "\"");
    bs = (c == "\\");
    pr = (c >= 8'd32) && (c < 8'd127);
    case (s)
      LX_SIGN: begin
        if (sp) return LX_END_SYMBOL;
        if (dg) return LX_DIGITS;
        if (dt) return LX_DOT_BEFORE;
        if (pr) return LX_SYM;
      end
      LX_DIGITS: begin
        if (sp) return LX_END_NUMBER;
        if (dg) return LX_DIGITS;
        if (ex) return LX_EXP;
        if (dt) return LX_DOT_AFTER;
      end
      LX_DOT_AFTER, LX_FRAC: begin
        if (sp) return LX_END_NUMBER;
        if (dg) return LX_FRAC;
        if (ex) return LX_EXP;
      end
      LX_DOT_BEFORE: begin
        if (sp) return LX_END_SYMBOL;
        if (dg) return LX_FRAC;
        if (ex) return LX_EXP;
        if (pr) return LX_SYM;
      end
      LX_EXP: begin
        if (sg) return LX_EXP_SIGN;
        if (dg) return LX_EXP_DIGITS;
      end
      LX_EXP_SIGN: begin
        if (dg) return LX_EXP_DIGITS;
      end
      LX_EXP_DIGITS: begin
        if (sp) return LX_END_NUMBER;
        if (dg) return LX_EXP_DIGITS;
      end
      LX_STR_START: begin
        if (qt) return LX_END_STRING;
        if (pr && !bs) return LX_STR_TEXT;
      end
      LX_STR_TEXT, LX_STR_ESCAPED: begin
        if (qt) return LX_END_STRING;
        if (bs) return LX_STR_ESC;
        if (pr) return LX_STR_TEXT;
      end
      LX_STR_ESC: begin
        if (pr) return LX_STR_ESCAPED;
      end
      LX_SYM: begin
        if (sp) return LX_END_SYMBOL;
        if (pr) return LX_SYM;
      end
      default: begin
        if (sp) return LX_NEUTRAL;
        if (sg) return LX_SIGN;
        if (dg) return LX_DIGITS;
        if (dt) return LX_DOT_BEFORE;
        if (qt) return LX_STR_START;
        if (pr) return LX_SYM;
      end
    endcase
    return LX_BAD;
  endfunction

  always @(posedge clk) begin
    lex_state_e  nxt;
    lex_result_t want, got;
    if (!rst_n) begin
      lex_st = LX_NEUTRAL;
      lex_results_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        nxt       = lex_transition(lex_st, in_char_in);
        want.ch   = in_char_in;
        want.tok  = 1'b0;
        want.done = DONE_NONE;
        want.err  = 1'b0;
        case (nxt)
          LX_END_NUMBER: begin want.done = DONE_NUMBER; nxt = LX_NEUTRAL; end
          LX_END_STRING: begin want.done = DONE_STRING; nxt = LX_NEUTRAL; end
          LX_END_SYMBOL: begin want.done = DONE_SYMBOL; nxt = LX_NEUTRAL; end
          LX_BAD:        begin want.err  = 1'b1;        nxt = LX_NEUTRAL; end
          LX_NEUTRAL, LX_STR_START: ;
          default: want.tok = 1'b1;
        endcase
        lex_st = nxt;
        lex_results_q.insert(lex_results_q.size(), want);
      end
      if (out_valid && out_ready) begin
        got = '{out_char_out, out_in_token, out_token_done, out_lex_error};
        if (lex_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: unexpected transfer ch=%h tok=%b done=%0d err=%b",
                     $realtime, got.ch, got.tok, got.done, got.err);
        end else begin
          want = lex_results_q.pop_front();
          if (got.ch !== want.ch || got.tok !== want.tok ||
              got.done !== want.done || got.err !== want.err) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: exp ch=%h tok=%b done=%0d err=%b got ch=%h tok=%b done=%0d err=%b",
                       $realtime, want.ch, want.tok, want.done, want.err,
                       got.ch, got.tok, got.done, got.err);
          end
        end
      end
    end
    pending = lex_results_q.size();
  end

endmodule

// ===== tb/forth_token_lexer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_token_lexer_test: stimulus and verdict for the token lexer
// Feeds a directed character run and then random token streams under three
// backpressure mixes; a side checker predicts and compares every transfer.
// ----------------------------------------------------------------------------
module forth_token_lexer_test;
  import ftl_pkg::*;

  localparam int PHASE_CHARS = 460;   // random characters per idling phase
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT  = 8;     // margin after the checker queue empties

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  char_t in_char_in = 8'h00;
  logic  out_valid;
  logic  out_ready = 1'b0;
  char_t out_char_out;
  logic  out_in_token;
  done_t out_token_done;
  logic  out_lex_error;

  int fail_count;
  int pending;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int chars_sent   = 0;

  char_t char_stream[$];

  forth_token_lexer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_in_token   (out_in_token),
    .out_token_done (out_token_done),
    .out_lex_error  (out_lex_error)
  );

  ftl_token_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_in_token   (out_in_token),
    .out_token_done (out_token_done),
    .out_lex_error  (out_lex_error),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: ready drops at random per cycle, at the rate of the phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // one character transfer; valid only drops inside an idle gap, so a
  // back-to-back stream never lowers and raises it in the same step
  task automatic send_char(input char_t c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  function automatic char_t pick_print();
    return char_t'($urandom_range(32, 126));
  endfunction

  function automatic char_t pick_digit();
    return char_t'($urandom_range(48, 57));
  endfunction

  // Append one word to the stream: mostly well-formed numbers, strings and
  // symbols with random content, some raw noise bytes and some tokens with
  // one character swapped for an arbitrary byte.
  task automatic queue_word();
    char_t w[$];
    char_t c;
    int    kind, n;
    kind = $urandom_range(99);
    if (kind < 10) begin
      w.insert(w.size(), char_t'($urandom_range(0, 255)));
    end else if (kind < 45) begin
      // number: [sign] [digits] [. [digits]] [e [sign] digits], some mantissa digit
      if ($urandom_range(2) == 0) w.insert(w.size(), $urandom_range(1) ? "+" : "-");
      n = $urandom_range(0, 4);
      repeat (n) w.insert(w.size(), pick_digit());
      if (n == 0 || $urandom_range(1)) begin
        w.insert(w.size(), ".");
        repeat ($urandom_range((n == 0) ? 1 : 0, 3)) w.insert(w.size(), pick_digit());
      end
      if ($urandom_range(2) == 0) begin
        w.insert(w.size(), $urandom_range(1) ? "e" : "E");
        if ($urandom_range(1)) w.insert(w.size(), $urandom_range(1) ? "+" : "-");
        repeat ($urandom_range(1, 3)) w.insert(w.size(), pick_digit());
      end
    end else if (kind < 70) begin
      // string; an escape never directly follows the opening quote
      w.insert(w.size(), "\"");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(4) == 0) begin
          w.insert(w.size(), "\\");
          w.insert(w.size(), pick_print());
        end else begin
          do c = pick_print(); while (c == "\"" || c == "\\");
          w.insert(w.size(), c);
        end
      end
      w.insert(w.size(), "\"");
    end else begin
      // symbol: leading char that cannot open a number or a string
      do c = pick_print();
      while (c == " " || c == "\"" || c == "." || c == "+" || c == "-" ||
             (c >= "0" && c <= "9"));
      w.insert(w.size(), c);
      repeat ($urandom_range(0, 5)) begin
        do c = pick_print(); while (c == " ");
        w.insert(w.size(), c);
      end
    end
    // broken token: one position replaced by any byte
    if (kind >= 10 && $urandom_range(6) == 0)
      w[$urandom_range(0, w.size() - 1)] = char_t'($urandom_range(0, 255));
    w.insert(w.size(), " ");
    if ($urandom_range(7) == 0) w.insert(w.size(), " ");
    char_stream = {char_stream, w};
  endtask

  initial begin
    string directed;
    directed = "-1.5e+9 \"a\\\"\" \"\\. +x ";

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin in_idle_pct = 18; out_idle_pct = 72; end
        1: begin in_idle_pct = 72; out_idle_pct = 18; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      if (ph == 0) begin
        // full number, string with an escaped quote, backslash right after
        // an opening quote, lone dot and sign symbols, then byte extremes
        for (int i = 0; i < directed.len(); i++) send_char(char_t'(directed[i]));
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h7F);
        send_char(8'h80);
      end
      while (chars_sent < (ph + 1) * PHASE_CHARS + 25) begin
        queue_word();
        while (char_stream.size() != 0) send_char(char_stream.pop_front());
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog: ends the run when no transfer happens for too long
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
